@@ src/llgl_pkg.sv @@
// types, constants and the digit step shared by the grid locator modules
`default_nettype none
package llgl_pkg;

   // fixed point format of the coordinates
   localparam int FRAC_BITS = 20;
   localparam int COORD_W   = 29;
   localparam int MAX_PAIRS = 6;
   localparam int LEN_W     = 4;

   // spans in whole degrees and the remainder widths that follow
   localparam int LON_SPAN  = 360;
   localparam int LAT_SPAN  = 180;
   localparam int SPAN_W    = 9;
   localparam int RAD_W     = 5;
   localparam int MAX_RADIX = 24;
   localparam int R_W       = SPAN_W + FRAC_BITS;
   localparam int P_W       = R_W + RAD_W;
   localparam int T_W       = P_W - FRAC_BITS;
   localparam int CHAR_W    = 7;
   localparam int IDX_W     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CNT_W     = $clog2(MAX_PAIRS + 1);

   // half spans in fixed point, used for the range check and the offset
   localparam longint LON_HALF_L = longint'(LON_SPAN / 2) << FRAC_BITS;
   localparam longint LAT_HALF_L = longint'(LAT_SPAN / 2) << FRAC_BITS;

   // locator alphabet
   localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT = 7'h30;

   // work item handed from cell to cell
   typedef struct packed {
      logic                               err;
      logic [IDX_W-1:0]                   last_idx;
      logic [R_W-1:0]                     r_lon;
      logic [R_W-1:0]                     r_lat;
      logic [MAX_PAIRS-1:0][CHAR_W-1:0]   lon_chars;
      logic [MAX_PAIRS-1:0][CHAR_W-1:0]   lat_chars;
   } stage_type;

   // one digit of the mixed radix expansion
   typedef struct packed {
      logic [RAD_W-1:0] q;
      logic [R_W-1:0]   r;
   } digit_type;

   // radix of pair k: 18 first, then 10 and 24 in turn
   function automatic logic [RAD_W-1:0] cell_radix(input int k);
      if (k == 0) begin
         return RAD_W'(18);
      end else if ((k % 2) == 1) begin
         return RAD_W'(10);
      end else begin
         return RAD_W'(24);
      end
   endfunction

   // character base of pair k
   function automatic logic [CHAR_W-1:0] cell_base(input int k);
      if (k == 0) begin
         return CHAR_UPPER;
      end else if ((k % 2) == 1) begin
         return CHAR_DIGIT;
      end else begin
         return CHAR_LOWER;
      end
   endfunction

   // r * radix split into quotient and remainder over span << FRAC_BITS
   function automatic digit_type digit_step(input logic [R_W-1:0]    r,
                                            input logic [RAD_W-1:0]  radix,
                                            input logic [SPAN_W-1:0] span);
      logic [P_W-1:0]   prod;
      logic [T_W-1:0]   t;
      logic [T_W-1:0]   sub;
      logic [T_W-1:0]   rem;
      logic [T_W-1:0]   mult;
      logic [RAD_W-1:0] q;
      digit_type        d;
      prod = P_W'(r) * P_W'(radix);
      t    = prod[P_W-1:FRAC_BITS];
      q    = '0;
      sub  = '0;
      // the highest multiple of the span not above t
      for (int j = 1; j < MAX_RADIX; j++) begin
         mult = T_W'(j) * T_W'(span);
         if ((RAD_W'(j) < radix) && (t >= mult)) begin
            q   = RAD_W'(j);
            sub = mult;
         end
      end
      rem = t - sub;
      d.q = q;
      d.r = {rem[SPAN_W-1:0], prod[FRAC_BITS-1:0]};
      return d;
   endfunction

endpackage
`default_nettype wire

@@ src/llgl_front.sv @@
// input stage: range and length check, offset and clamp of both coordinates
`default_nettype none
module llgl_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic [llgl_pkg::COORD_W-1:0]        latitude,
   input  wire logic [llgl_pkg::COORD_W-1:0]        longitude,
   input  wire logic [llgl_pkg::LEN_W-1:0]          locator_length,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output llgl_pkg::stage_type                      out_data
);

   localparam int S_W = llgl_pkg::COORD_W + 1;
   localparam logic signed [S_W-1:0] LON_HALF = S_W'(llgl_pkg::LON_HALF_L);
   localparam logic signed [S_W-1:0] LAT_HALF = S_W'(llgl_pkg::LAT_HALF_L);
   localparam logic signed [S_W-1:0] LON_FULL = S_W'(2 * llgl_pkg::LON_HALF_L);
   localparam logic signed [S_W-1:0] LAT_FULL = S_W'(2 * llgl_pkg::LAT_HALF_L);

   logic                 valid_ff;
   llgl_pkg::stage_type  data_ff;
   llgl_pkg::stage_type  data_in;
   logic signed [S_W-1:0] lat_s;
   logic signed [S_W-1:0] lon_s;
   logic signed [S_W-1:0] lat_sum;
   logic signed [S_W-1:0] lon_sum;
   logic [llgl_pkg::LEN_W-2:0] half_len;
   logic [llgl_pkg::CNT_W-1:0] pairs;

   // stage moves on when empty or when the next cell takes it
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // checks and offsets
   always_comb begin
      lat_s    = {latitude[llgl_pkg::COORD_W-1], latitude};
      lon_s    = {longitude[llgl_pkg::COORD_W-1], longitude};
      lat_sum  = lat_s + LAT_HALF;
      lon_sum  = lon_s + LON_HALF;
      half_len = locator_length[llgl_pkg::LEN_W-1:1];
      if (llgl_pkg::CNT_W'(half_len) > llgl_pkg::CNT_W'(llgl_pkg::MAX_PAIRS)) begin
         pairs = llgl_pkg::CNT_W'(llgl_pkg::MAX_PAIRS);
      end else begin
         pairs = llgl_pkg::CNT_W'(half_len);
      end
      data_in          = '0;
      data_in.err      = (locator_length < llgl_pkg::LEN_W'(2)) || locator_length[0] ||
                         (lon_s < -LON_HALF) || (lon_s > LON_HALF) ||
                         (lat_s < -LAT_HALF) || (lat_s > LAT_HALF);
      data_in.last_idx = llgl_pkg::IDX_W'(pairs - llgl_pkg::CNT_W'(1));
      // exactly +180 or +90 falls into the top cell
      if (lon_sum >= LON_FULL) begin
         data_in.r_lon = llgl_pkg::R_W'(LON_FULL - S_W'(1));
      end else begin
         data_in.r_lon = lon_sum[llgl_pkg::R_W-1:0];
      end
      if (lat_sum >= LAT_FULL) begin
         data_in.r_lat = llgl_pkg::R_W'(LAT_FULL - S_W'(1));
      end else begin
         data_in.r_lat = lat_sum[llgl_pkg::R_W-1:0];
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

@@ src/llgl_cell.sv @@
// one cell of the chain: works out one character pair and passes the item on
`default_nettype none
module llgl_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [llgl_pkg::RAD_W-1:0]        radix,
   input  wire logic [llgl_pkg::CHAR_W-1:0]       base,
   input  wire logic [llgl_pkg::IDX_W-1:0]        slot,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire llgl_pkg::stage_type               in_data,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output llgl_pkg::stage_type                    out_data
);

   logic                  valid_ff;
   llgl_pkg::stage_type   data_ff;
   llgl_pkg::stage_type   data_in;
   llgl_pkg::digit_type   lon_dig;
   llgl_pkg::digit_type   lat_dig;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // next digit of both coordinates
   always_comb begin
      lon_dig = llgl_pkg::digit_step(in_data.r_lon, radix,
                                     llgl_pkg::SPAN_W'(llgl_pkg::LON_SPAN));
      lat_dig = llgl_pkg::digit_step(in_data.r_lat, radix,
                                     llgl_pkg::SPAN_W'(llgl_pkg::LAT_SPAN));
      data_in                  = in_data;
      data_in.r_lon            = lon_dig.r;
      data_in.r_lat            = lat_dig.r;
      data_in.lon_chars[slot]  = base + llgl_pkg::CHAR_W'(lon_dig.q);
      data_in.lat_chars[slot]  = base + llgl_pkg::CHAR_W'(lat_dig.q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

@@ src/llgl_serial.sv @@
// output stage: sends the pairs of one item one transaction at a time
`default_nettype none
module llgl_serial (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire llgl_pkg::stage_type               in_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [llgl_pkg::CHAR_W-1:0]            rsp_lon_char,
   output logic [llgl_pkg::CHAR_W-1:0]            rsp_lat_char,
   output logic                                   rsp_error,
   output logic                                   rsp_last
);

   logic                         valid_ff;
   llgl_pkg::stage_type          data_ff;
   logic [llgl_pkg::IDX_W-1:0]   idx_ff;
   logic [llgl_pkg::IDX_W-1:0]   idx_in;
   logic                         take;

   // current pair
   always_comb begin
      rsp_valid = valid_ff;
      rsp_error = data_ff.err;
      rsp_last  = data_ff.err || (idx_ff == data_ff.last_idx);
      if (data_ff.err) begin
         rsp_lon_char = '0;
         rsp_lat_char = '0;
      end else begin
         rsp_lon_char = data_ff.lon_chars[idx_ff];
         rsp_lat_char = data_ff.lat_chars[idx_ff];
      end
      take     = valid_ff && rsp_ready;
      in_ready = !valid_ff || (rsp_ready && rsp_last);
      if (in_ready) begin
         idx_in = '0;
      end else if (take) begin
         idx_in = idx_ff + llgl_pkg::IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         idx_ff <= idx_in;
         if (in_ready) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule
`default_nettype wire

@@ src/latlon_to_grid_locator_top.sv @@
// top level of the latitude/longitude to grid locator encoder
// Encodes a latitude and longitude (signed degrees times 2^20) into a grid locator,
// one transaction per character pair (longitude char, latitude char), tlast on the final
// pair. The locator_length register (reset 6) sets the pair count, saturating at six;
// an odd or short length or a coordinate beyond +-180/+-90 degrees gives one transaction
// with tuser set, tlast set and zero characters. The request passes a check stage, a
// chain of six digit cells, one per pair, and the output stage, each registered. The output
// stage sends one pair per cycle while rsp_tready is high, and takes the next item when the
// last pair of the current one is accepted; the chain takes a new request every cycle
// while earlier items are still moving, unless back-pressure from the output holds it.
`default_nettype none
module latlon_to_grid_locator_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // latitude [28:0], longitude [57:29], zero [63:58]
   input  wire logic [63:0]  req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // lon_char [6:0], lat_char [13:7], zero [15:14]
   output logic [15:0]       rsp_tdata,
   // error [0]
   output logic              rsp_tuser,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [3:0]   csr_data,
   input  wire logic         csr_valid,
   output logic              csr_ready
);

   localparam int N = llgl_pkg::MAX_PAIRS;

   logic [llgl_pkg::LEN_W-1:0]  locator_length_ff;
   logic                        stage_valid [0:N];
   logic                        stage_ready [0:N];
   llgl_pkg::stage_type         stage_data  [0:N];
   logic [llgl_pkg::CHAR_W-1:0] lon_char;
   logic [llgl_pkg::CHAR_W-1:0] lat_char;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         locator_length_ff <= llgl_pkg::LEN_W'(6);
      end else if (csr_valid && csr_ready) begin
         locator_length_ff <= csr_data;
      end
   end

   // check and offset stage
   llgl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .latitude       (req_tdata[28:0]),
      .longitude      (req_tdata[57:29]),
      .locator_length (locator_length_ff),
      .out_valid      (stage_valid[0]),
      .out_ready      (stage_ready[0]),
      .out_data       (stage_data[0])
   );

   // chain of digit cells, one per pair
   for (genvar g = 0; g < N; g++) begin : g_cell
      llgl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .radix     (llgl_pkg::cell_radix(g)),
         .base      (llgl_pkg::cell_base(g)),
         .slot      (llgl_pkg::IDX_W'(g)),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   // pair by pair output
   llgl_serial u_serial (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (stage_valid[N]),
      .in_ready     (stage_ready[N]),
      .in_data      (stage_data[N]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_lon_char (lon_char),
      .rsp_lat_char (lat_char),
      .rsp_error    (rsp_tuser),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, lat_char, lon_char};

endmodule
`default_nettype wire

@@ tb/sv/tb_latlon_to_grid_locator_top.sv @@
// self-checking testbench for the grid locator encoder: queued stimulus, driver and monitor
`default_nettype none
module tb_latlon_to_grid_locator_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_GUARD    = 16;
   localparam int PHASE_ITEMS    = 26;
   localparam int PRINT_LIMIT    = 50;

   // one expected character pair
   typedef struct packed {
      logic [llgl_pkg::CHAR_W-1:0] lon_char;
      logic [llgl_pkg::CHAR_W-1:0] lat_char;
      logic                        err;
      logic                        last;
   } locator_pair_type;

   // idling styles of the phases
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic [63:0] req_tdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [3:0]  csr_data   = '0;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;

   // coordinate transactions waiting to be offered, and pairs still owed by the block
   logic [63:0]      coord_queue[$];
   locator_pair_type pair_queue[$];

   // testbench copy of the locator length register
   logic [llgl_pkg::LEN_W-1:0] length_reg = 4'd6;

   logic req_fired   = 1'b0;
   int   sender_idle = 0;
   int   rsp_stall   = 0;
   int   idle_cycles = 0;

   int coords_taken  = 0;
   int pairs_checked = 0;
   int error_results = 0;
   int length_writes = 0;
   int fail_count    = 0;

   latlon_to_grid_locator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // one line per mismatch, the count goes on past the print limit
   task automatic report_mismatch(input string what, input int got, input int want);
      if (fail_count < PRINT_LIMIT) begin
         $display("mismatch at pair %0d: %s got %0d want %0d", pairs_checked, what, got, want);
      end
      fail_count++;
   endtask

   // expand one coordinate into the locator pairs the block should send
   function automatic void predict_locator(input logic [llgl_pkg::COORD_W-1:0] lat_raw,
                                           input logic [llgl_pkg::COORD_W-1:0] lon_raw);
      longint                      lat;
      longint                      lon;
      longint                      lon_half;
      longint                      lat_half;
      longint                      lon_span;
      longint                      lat_span;
      longint                      lon_rem;
      longint                      lat_rem;
      longint                      lon_q;
      longint                      lat_q;
      int                          npairs;
      int                          radix;
      logic [llgl_pkg::CHAR_W-1:0] base;
      locator_pair_type            pr;
      lat      = longint'($signed(lat_raw));
      lon      = longint'($signed(lon_raw));
      lon_half = longint'(180) << llgl_pkg::FRAC_BITS;
      lat_half = longint'(90) << llgl_pkg::FRAC_BITS;
      lon_span = 2 * lon_half;
      lat_span = 2 * lat_half;
      // bad length or coordinate off the globe: a single flagged pair
      if (length_reg < 2 || length_reg[0] ||
          lon < -lon_half || lon > lon_half || lat < -lat_half || lat > lat_half) begin
         pr.lon_char = '0;
         pr.lat_char = '0;
         pr.err      = 1'b1;
         pr.last     = 1'b1;
         pair_queue.push_back(pr);
         return;
      end
      npairs = int'(length_reg) / 2;
      if (npairs > llgl_pkg::MAX_PAIRS) begin
         npairs = llgl_pkg::MAX_PAIRS;
      end
      // shift to unsigned, the north and east poles clamp into the top cell
      lon_rem = lon + lon_half;
      lat_rem = lat + lat_half;
      if (lon_rem >= lon_span) begin
         lon_rem = lon_span - 1;
      end
      if (lat_rem >= lat_span) begin
         lat_rem = lat_span - 1;
      end
      // mixed radix digits: 18 upper letters, then digits and lower letters in turn
      for (int k = 0; k < npairs; k++) begin
         if (k == 0) begin
            radix = 18;
            base  = 7'h41;
         end else if (k % 2 == 1) begin
            radix = 10;
            base  = 7'h30;
         end else begin
            radix = 24;
            base  = 7'h61;
         end
         lon_rem     = lon_rem * radix;
         lat_rem     = lat_rem * radix;
         lon_q       = lon_rem / lon_span;
         lat_q       = lat_rem / lat_span;
         lon_rem     = lon_rem - lon_q * lon_span;
         lat_rem     = lat_rem - lat_q * lat_span;
         pr.lon_char = base + llgl_pkg::CHAR_W'(lon_q);
         pr.lat_char = base + llgl_pkg::CHAR_W'(lat_q);
         pr.err      = 1'b0;
         pr.last     = (k + 1 == npairs);
         pair_queue.push_back(pr);
      end
   endfunction

   // random coordinate: mostly on the globe, some edges, some beyond
   function automatic logic [llgl_pkg::COORD_W-1:0] random_coord(input longint half);
      longint v;
      longint deg;
      deg = half >>> llgl_pkg::FRAC_BITS;
      case ($urandom_range(19))
         0: begin
            v = longint'($urandom());
         end
         1: begin
            v = half + 1 + longint'($urandom_range(4095));
         end
         2: begin
            v = -half - 1 - longint'($urandom_range(4095));
         end
         3: begin
            case ($urandom_range(6))
               0:       v = half;
               1:       v = -half;
               2:       v = 0;
               3:       v = -1;
               4:       v = half - 1;
               5:       v = -half + 1;
               default: v = 1;
            endcase
         end
         4, 5: begin
            v = (longint'($urandom_range(int'(2 * deg))) - deg) <<< llgl_pkg::FRAC_BITS;
         end
         default: begin
            v = longint'($urandom_range(int'(2 * half))) - half;
         end
      endcase
      return v[llgl_pkg::COORD_W-1:0];
   endfunction

   // queue one coordinate transaction: latitude low, longitude above
   function automatic void queue_coord(input longint lat, input longint lon);
      logic [llgl_pkg::COORD_W-1:0] lat_bits;
      logic [llgl_pkg::COORD_W-1:0] lon_bits;
      lat_bits = lat[llgl_pkg::COORD_W-1:0];
      lon_bits = lon[llgl_pkg::COORD_W-1:0];
      coord_queue.push_back({6'b0, lon_bits, lat_bits});
   endfunction

   // set the idling of both sides
   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle = 0;
            rsp_stall   = 0;
         end
         IDLE_SENDER: begin
            sender_idle = 53;
            rsp_stall   = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle = 0;
            rsp_stall   = 53;
         end
         default: begin
            sender_idle = 14;
            rsp_stall   = 14;
         end
      endcase
   endtask

   // hold off until every coordinate is taken and every pair has come back
   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (coord_queue.size() != 0 || req_tvalid || pair_queue.size() != 0);
      repeat (DRAIN_GUARD) @(posedge clock);
   endtask

   // register write transaction, only issued while the block is idle
   task automatic write_length(input logic [llgl_pkg::LEN_W-1:0] value);
      @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver and response back-pressure, changing on the falling edge
   always @(negedge clock) begin : driver
      logic [63:0] next_data;
      logic        next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         next_data  = req_tdata;
         next_valid = req_tvalid;
         if (!req_tvalid || req_fired) begin
            next_valid = 1'b0;
            if (coord_queue.size() != 0 && $urandom_range(99) >= sender_idle) begin
               next_data  = coord_queue.pop_front();
               next_valid = 1'b1;
            end
         end
         req_tdata  <= next_data;
         req_tvalid <= next_valid;
         rsp_tready <= ($urandom_range(99) >= rsp_stall);
      end
   end

   // monitor: predict on each accepted coordinate, check each accepted pair
   always @(posedge clock) begin : monitor
      locator_pair_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            predict_locator(req_tdata[llgl_pkg::COORD_W-1:0],
                            req_tdata[2*llgl_pkg::COORD_W-1:llgl_pkg::COORD_W]);
            coords_taken++;
         end
         if (csr_valid && csr_ready) begin
            length_reg = csr_data;
            length_writes++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pair_queue.size() == 0) begin
               report_mismatch("pair with nothing expected, lon_char",
                               int'(rsp_tdata[6:0]), 0);
            end else begin
               want = pair_queue.pop_front();
               if (rsp_tdata[6:0] !== want.lon_char) begin
                  report_mismatch("lon_char", int'(rsp_tdata[6:0]), int'(want.lon_char));
               end
               if (rsp_tdata[13:7] !== want.lat_char) begin
                  report_mismatch("lat_char", int'(rsp_tdata[13:7]), int'(want.lat_char));
               end
               if (rsp_tuser !== want.err) begin
                  report_mismatch("error", int'(rsp_tuser), int'(want.err));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch("last", int'(rsp_tlast), int'(want.last));
               end
               if (want.err) begin
                  error_results++;
               end
            end
            pairs_checked++;
         end
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d pairs outstanding",
                     idle_cycles, pair_queue.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin : stimulus
      longint                     one;
      longint                     lon_half;
      longint                     lat_half;
      longint                     coord_min;
      longint                     coord_max;
      logic [llgl_pkg::LEN_W-1:0] lengths[12];
      one       = longint'(1) << llgl_pkg::FRAC_BITS;
      lon_half  = 180 * one;
      lat_half  = 90 * one;
      coord_min = -(longint'(1) << (llgl_pkg::COORD_W - 1));
      coord_max = (longint'(1) << (llgl_pkg::COORD_W - 1)) - 1;
      lengths   = '{4'd12, 4'd2, 4'd0, 4'd14, 4'd8, 4'd1, 4'd15, 4'd10, 4'd4, 4'd13,
                    4'd6, 4'd12};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset length
      set_idle(IDLE_NONE);
      queue_coord(0, 0);
      queue_coord(-1, -1);
      queue_coord(1, 1);
      // poles and antimeridian, the north and east edges clamped into the top cell
      queue_coord(lat_half, lon_half);
      queue_coord(-lat_half, -lon_half);
      queue_coord(lat_half, -lon_half);
      queue_coord(-lat_half, lon_half);
      queue_coord(lat_half - 1, lon_half - 1);
      // one step beyond the valid range
      queue_coord(lat_half + 1, 0);
      queue_coord(-lat_half - 1, 0);
      queue_coord(0, lon_half + 1);
      queue_coord(0, -lon_half - 1);
      // field extremes
      queue_coord(coord_min, coord_min);
      queue_coord(coord_max, coord_max);
      queue_coord(coord_min, 0);
      queue_coord(0, coord_max);
      // zone and square boundaries
      queue_coord(10 * one, 20 * one);
      queue_coord(10 * one - 1, 20 * one - 1);
      queue_coord(-10 * one, -20 * one);
      queue_coord(one, 2 * one);
      queue_coord((longint'(515) * one) / 10, -one / 10);
      queue_coord((-longint'(339) * one) / 10, (longint'(1512) * one) / 10);
      wait_drained();

      // random phases, each with its length write and idling style
      for (int p = 0; p < 12; p++) begin
         write_length(lengths[p]);
         set_idle(idle_mode_type'(p % 4));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            coord_queue.push_back({6'b0, random_coord(lon_half), random_coord(lat_half)});
         end
         wait_drained();
      end

      if (pair_queue.size() != 0) begin
         report_mismatch("pairs never delivered", 0, pair_queue.size());
      end
      $display("ran %0d coordinates over %0d length writes with four idling styles",
               coords_taken, length_writes);
      $display("checked %0d locator pairs, %0d of them flagged as errors",
               pairs_checked, error_results);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
src/llgl_pkg.sv
src/llgl_front.sv
src/llgl_cell.sv
src/llgl_serial.sv
src/latlon_to_grid_locator_top.sv
tb/sv/tb_latlon_to_grid_locator_top.sv
